// ===== design/stalarm_pkg.sv =====
// ----------------------------------------------------------------------------
// stalarm_pkg
// Shared widths, codes and types for the sustained threshold alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package stalarm_pkg;

    localparam int TIME_W   = 32;
    localparam int PCT_W    = 14;
    localparam int RATE_W   = 40;
    localparam int VALUE_W  = 40;
    localparam int METRIC_W = 3;
    localparam int MS_W     = 27;
    localparam int SUSR_W   = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 80;

    // Reciprocal of 125 scaled by 2^32 and rounded up.
    localparam logic [25:0] SUS_RECIP_125 = 26'd34359739;

    // Metric codes.
    localparam logic [METRIC_W-1:0] METRIC_CPU      = 3'd0;
    localparam logic [METRIC_W-1:0] METRIC_MEMORY   = 3'd1;
    localparam logic [METRIC_W-1:0] METRIC_DOWNLOAD = 3'd2;
    localparam logic [METRIC_W-1:0] METRIC_UPLOAD   = 3'd3;
    localparam logic [METRIC_W-1:0] METRIC_LINK     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RULE_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_BELOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_MS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd5;

    // Event kinds.
    localparam logic EVENT_TRIGGERED = 1'b0;
    localparam logic EVENT_RECOVERED = 1'b1;

    typedef struct packed {
        logic                rule_enabled;
        logic [METRIC_W-1:0] metric_select;
        logic                trigger_below;
        logic [VALUE_W-1:0]  threshold;
        logic [SUSR_W-1:0]   sustain_round;  // sustain rounded up to whole seconds
        logic [MS_W-1:0]     cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [VALUE_W-1:0] value;
    } sample_t;

    typedef struct packed {
        logic                kind;
        logic [METRIC_W-1:0] metric;
        logic [VALUE_W-1:0]  value;
        logic [TIME_W-1:0]   time_ms;
    } event_t;

endpackage

`default_nettype wire

// ===== design/stalarm_cfg.sv =====
// ----------------------------------------------------------------------------
// stalarm_cfg
// Configuration registers, with the sustain time rounded up to seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module stalarm_cfg (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [stalarm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stalarm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output stalarm_pkg::cfg_t                          cfg
);

    // Whole elapsed seconds reach the sustain time exactly when the raw
    // elapsed time reaches 1000 * ceil(sustain / 1000). The quotient uses
    // (s + 999) / 8 times a reciprocal of 125 scaled by 2^32.

    stalarm_pkg::cfg_t cfg_reg;
    stalarm_pkg::cfg_t cfg_next;

    logic [27:0] sus_bias;
    logic [24:0] sus_div8;
    logic [50:0] sus_prod;
    logic [17:0] sus_sec;
    logic [stalarm_pkg::SUSR_W-1:0] sus_round;

    always_comb begin
        sus_bias  = {1'b0, cfg_wdata[stalarm_pkg::MS_W-1:0]} + 28'd999;
        sus_div8  = sus_bias[27:3];
        sus_prod  = {26'd0, sus_div8} * {25'd0, stalarm_pkg::SUS_RECIP_125};
        sus_sec   = sus_prod[49:32];
        sus_round = {sus_sec, 10'd0} - {6'd0, sus_sec, 4'd0} - {7'd0, sus_sec, 3'd0};
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                stalarm_pkg::REG_RULE_ENABLED:  cfg_next.rule_enabled = cfg_wdata[0];
                stalarm_pkg::REG_METRIC_SELECT:
                    cfg_next.metric_select = cfg_wdata[stalarm_pkg::METRIC_W-1:0];
                stalarm_pkg::REG_TRIGGER_BELOW: cfg_next.trigger_below = cfg_wdata[0];
                stalarm_pkg::REG_THRESHOLD:
                    cfg_next.threshold = cfg_wdata[stalarm_pkg::VALUE_W-1:0];
                stalarm_pkg::REG_SUSTAIN_MS:    cfg_next.sustain_round = sus_round;
                stalarm_pkg::REG_COOLDOWN_MS:
                    cfg_next.cooldown_ms = cfg_wdata[stalarm_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/stalarm_in_stage.sv =====
// ----------------------------------------------------------------------------
// stalarm_in_stage
// Input register: takes a sample and keeps its time and selected metric.
// ----------------------------------------------------------------------------
`default_nettype none

module stalarm_in_stage (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    input  wire logic [stalarm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [stalarm_pkg::METRIC_W-1:0]      metric_select,
    input  wire logic                                  advance,
    output      logic                                  smp_valid,
    output      stalarm_pkg::sample_t                  smp
);

    logic                 valid_reg;
    logic                 valid_next;
    stalarm_pkg::sample_t smp_reg;
    stalarm_pkg::sample_t smp_next;
    logic                 take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        smp_next.time_ms = s_tdata[31:0];
        case (metric_select)
            stalarm_pkg::METRIC_CPU:      smp_next.value = {26'd0, s_tdata[45:32]};
            stalarm_pkg::METRIC_MEMORY:   smp_next.value = {26'd0, s_tdata[59:46]};
            stalarm_pkg::METRIC_DOWNLOAD: smp_next.value = s_tdata[99:60];
            stalarm_pkg::METRIC_UPLOAD:   smp_next.value = s_tdata[139:100];
            stalarm_pkg::METRIC_LINK:     smp_next.value = {39'd0, s_tdata[140]};
            default:                      smp_next.value = '0;
        endcase
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            smp_reg <= smp_next;
        end
    end

    assign smp_valid = valid_reg;
    assign smp       = smp_reg;

endmodule

`default_nettype wire

// ===== design/stalarm_eval.sv =====
// ----------------------------------------------------------------------------
// stalarm_eval
// Rule evaluation: breach test, alarm state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stalarm_eval (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire stalarm_pkg::cfg_t      cfg,
    input  wire logic                   smp_valid,
    input  wire stalarm_pkg::sample_t   smp,
    output      logic                   advance,
    output      logic                   evt_valid,
    output      stalarm_pkg::event_t    evt,
    input  wire logic                   evt_ready
);

    logic [stalarm_pkg::TIME_W-1:0] start_time_reg, start_time_next;
    logic                           start_valid_reg, start_valid_next;
    logic [stalarm_pkg::TIME_W-1:0] trig_time_reg, trig_time_next;
    logic                           trig_valid_reg, trig_valid_next;
    logic                           active_reg, active_next;
    logic                           out_valid_reg, out_valid_next;
    stalarm_pkg::event_t            evt_reg, evt_next;

    logic                           breach;
    logic [stalarm_pkg::TIME_W-1:0] start_eff;
    logic [stalarm_pkg::TIME_W-1:0] elapsed;
    logic [stalarm_pkg::TIME_W-1:0] since_trig;
    logic                           sustained;
    logic                           cooled;
    logic                           fire;
    logic                           emit;

    // The sample moves on whenever the result slot is free or being drained.
    assign advance = smp_valid && (!out_valid_reg || evt_ready);

    always_comb begin
        breach     = cfg.trigger_below ? (smp.value < cfg.threshold)
                                       : (smp.value > cfg.threshold);
        start_eff  = start_valid_reg ? start_time_reg : smp.time_ms;
        elapsed    = smp.time_ms - start_eff;
        since_trig = smp.time_ms - trig_time_reg;
        sustained  = elapsed >= {4'd0, cfg.sustain_round};
        cooled     = !trig_valid_reg || (since_trig >= {5'd0, cfg.cooldown_ms});
        fire       = !active_reg && sustained && cooled;

        start_time_next  = start_time_reg;
        start_valid_next = start_valid_reg;
        trig_time_next   = trig_time_reg;
        trig_valid_next  = trig_valid_reg;
        active_next      = active_reg;
        emit             = 1'b0;

        evt_next.kind    = breach ? stalarm_pkg::EVENT_TRIGGERED
                                  : stalarm_pkg::EVENT_RECOVERED;
        evt_next.metric  = cfg.metric_select;
        evt_next.value   = smp.value;
        evt_next.time_ms = smp.time_ms;

        if (advance && cfg.rule_enabled) begin
            if (breach) begin
                start_valid_next = 1'b1;
                start_time_next  = start_eff;
                if (fire) begin
                    active_next     = 1'b1;
                    trig_valid_next = 1'b1;
                    trig_time_next  = smp.time_ms;
                    emit            = 1'b1;
                end
            end else begin
                start_valid_next = 1'b0;
                start_time_next  = '0;
                if (active_reg) begin
                    active_next = 1'b0;
                    emit        = 1'b1;
                end
            end
        end

        if (advance) begin
            out_valid_next = emit;
        end else if (evt_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg  <= '0;
            start_valid_reg <= 1'b0;
            trig_time_reg   <= '0;
            trig_valid_reg  <= 1'b0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            start_time_reg  <= start_time_next;
            start_valid_reg <= start_valid_next;
            trig_time_reg   <= trig_time_next;
            trig_valid_reg  <= trig_valid_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            evt_reg <= evt_next;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt       = evt_reg;

endmodule

`default_nettype wire

// ===== design/sustained_threshold_alarm_top.sv =====
// Path: an accepted sample passes the evaluation stage and shows its event,
// if any, in the result register, given the output is free.
// Throughput: one sample per clock while the output is free, set by the
// single evaluation stage between the input register and the result register.
// Reset: synchronous active-low aresetn clears the control registers, the
// alarm state and both channel valids; the rule comes out of reset disabled.
// ----------------------------------------------------------------------------
// sustained_threshold_alarm_top
// One alarm rule with a sustain time and a cooldown, evaluated per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module sustained_threshold_alarm_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    // Configuration write port, register index per the rule's list.
    input  wire logic                                  cfg_wr_en,
    input  wire logic [stalarm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [stalarm_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Sample stream.
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    // s_tdata, from bit 0: sample_time_ms[31:0], cpu_percent_x100[45:32],
    // memory_percent_x100[59:46], download_rate[99:60], upload_rate[139:100],
    // link_up[140], zero fill [143:141].
    input  wire logic [stalarm_pkg::S_TDATA_W-1:0]     s_tdata,

    // Event stream.
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata, from bit 0: event_metric[2:0], event_value[42:3],
    // event_time_ms[74:43], zero fill [79:75].
    output      logic [stalarm_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: event_kind (0 triggered, 1 recovered).
    output      logic                                  m_tuser
);

    stalarm_pkg::cfg_t    cfg;
    stalarm_pkg::sample_t smp;
    stalarm_pkg::event_t  evt;
    logic                 smp_valid;
    logic                 advance;

    // The configuration registers hold the rule. The sustain time is kept
    // already rounded up to whole seconds, so the per-sample test is a
    // plain compare of the raw elapsed time.
    stalarm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The input stage registers the sample time and the selected metric.
    // It accepts a new sample whenever its slot is empty or being handed on,
    // so a waiting event does not stop the stream while the slot can move.
    stalarm_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .metric_select (cfg.metric_select),
        .advance       (advance),
        .smp_valid     (smp_valid),
        .smp           (smp)
    );

    // The evaluation stage runs the breach test against the stored state,
    // updates the state and loads the result register when an event fires.
    stalarm_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .smp_valid (smp_valid),
        .smp       (smp),
        .advance   (advance),
        .evt_valid (m_tvalid),
        .evt       (evt),
        .evt_ready (m_tready)
    );

    assign m_tdata = {5'd0, evt.time_ms, evt.value, evt.metric};
    assign m_tuser = evt.kind;

endmodule

`default_nettype wire

// ===== design/stalarm_checker.sv =====
// ----------------------------------------------------------------------------
// stalarm_checker
// Port-level checks on the event stream of the alarm top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stalarm_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [stalarm_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                              m_tuser
);

    logic seen_reg;
    logic last_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            last_kind_reg <= stalarm_pkg::EVENT_RECOVERED;
        end else if (m_tvalid && m_tready) begin
            seen_reg      <= 1'b1;
            last_kind_reg <= m_tuser;
        end
    end

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("event valid after reset");

    a_stall_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("event dropped while stalled");

    a_stall_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("event changed while stalled");

    // Events alternate, and the first one after reset is a trigger.
    a_alternate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |->
            (seen_reg ? (m_tuser != last_kind_reg)
                      : (m_tuser == stalarm_pkg::EVENT_TRIGGERED)))
        else $error("event kinds do not alternate");

endmodule

bind sustained_threshold_alarm_top stalarm_checker u_stalarm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: sustained threshold alarm testbench
// Feeds timestamped metric samples into the alarm rule, rewrites the rule's
// registers between phases while the block is idle, and checks every
// triggered and recovered event against an alarm tracker kept in step with
// each accepted sample.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stalarm_pkg::*;

    // A receiver hold-off long enough to back the block up to its input.
    localparam int LONG_HOLD = 300;
    // Cycles allowed for outstanding events to arrive before giving up.
    localparam int DRAIN_LIMIT = 1000;
    localparam logic [VALUE_W-1:0] MAX40   = 40'hFF_FFFF_FFFF;
    localparam logic [MS_W-1:0]    MAX27   = 27'h7FF_FFFF;
    localparam logic [VALUE_W-1:0] PCT_TOP = 40'd10000;

    // One sample, packed in the same order as s_tdata from the top bit down.
    typedef struct packed {
        logic                link_up;
        logic [RATE_W-1:0]   upload_rate;
        logic [RATE_W-1:0]   download_rate;
        logic [PCT_W-1:0]    memory_pct;
        logic [PCT_W-1:0]    cpu_pct;
        logic [TIME_W-1:0]   time_ms;
    } sample_fields_t;

    // Tracks the rule's registers and alarm state, and holds the events the
    // block still owes, oldest first.
    class alarm_rule_tracker;
        logic                enabled    = 1'b0;
        logic [METRIC_W-1:0] metric     = '0;
        logic                below      = 1'b0;
        logic [VALUE_W-1:0]  thr        = '0;
        logic [MS_W-1:0]     sustain    = '0;
        logic [MS_W-1:0]     cooldown   = '0;

        logic [TIME_W-1:0]   breach_start = '0;
        logic                breach_seen  = 1'b0;
        logic [TIME_W-1:0]   last_trig    = '0;
        logic                trig_seen    = 1'b0;
        logic                active       = 1'b0;

        event_t pending_events[$];
        int     errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RULE_ENABLED:  enabled  = val[0];
                REG_METRIC_SELECT: metric   = val[METRIC_W-1:0];
                REG_TRIGGER_BELOW: below    = val[0];
                REG_THRESHOLD:     thr      = val[VALUE_W-1:0];
                REG_SUSTAIN_MS:    sustain  = val[MS_W-1:0];
                REG_COOLDOWN_MS:   cooldown = val[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(sample_fields_t smp);
            logic [VALUE_W-1:0] value;
            logic [TIME_W-1:0]  elapsed;
            logic               breach;
            logic               cooled;
            event_t             ev;
            if (!enabled)
                return;
            case (metric)
                METRIC_CPU:      value = VALUE_W'(smp.cpu_pct);
                METRIC_MEMORY:   value = VALUE_W'(smp.memory_pct);
                METRIC_DOWNLOAD: value = smp.download_rate;
                METRIC_UPLOAD:   value = smp.upload_rate;
                METRIC_LINK:     value = VALUE_W'(smp.link_up);
                default:         value = '0;
            endcase
            breach = below ? (value < thr) : (value > thr);
            ev.metric  = metric;
            ev.value   = value;
            ev.time_ms = smp.time_ms;
            if (breach) begin
                if (!breach_seen) begin
                    breach_seen  = 1'b1;
                    breach_start = smp.time_ms;
                end
                // Breach duration counts in whole seconds only.
                elapsed = smp.time_ms - breach_start;
                elapsed = (elapsed / 1000) * 1000;
                cooled  = !trig_seen || ((smp.time_ms - last_trig) >= {5'd0, cooldown});
                if (!active && elapsed >= {5'd0, sustain} && cooled) begin
                    active    = 1'b1;
                    trig_seen = 1'b1;
                    last_trig = smp.time_ms;
                    ev.kind   = EVENT_TRIGGERED;
                    pending_events = {pending_events, ev};
                end
            end else begin
                breach_seen  = 1'b0;
                breach_start = '0;
                if (active) begin
                    active  = 1'b0;
                    ev.kind = EVENT_RECOVERED;
                    pending_events = {pending_events, ev};
                end
            end
        endfunction

        function void check_event(logic kind, logic [M_TDATA_W-1:0] data);
            event_t want;
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d metric %0d value %0d time %0d",
                       kind, data[2:0], data[42:3], data[74:43]);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            if (kind !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (data[2:0] !== want.metric) begin
                $error("event_metric: expected %0d, got %0d", want.metric, data[2:0]);
                errors++;
            end
            if (data[42:3] !== want.value) begin
                $error("event_value: expected %0d, got %0d", want.value, data[42:3]);
                errors++;
            end
            if (data[74:43] !== want.time_ms) begin
                $error("event_time_ms: expected %0d, got %0d", want.time_ms, data[74:43]);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     m_tuser;

    alarm_rule_tracker tracker;
    logic [TIME_W-1:0] cur_time;
    // Set by the stimulus to ask the event receiver for one long hold-off.
    bit                long_hold_req;
    // Remaining items of a run with no idle cycles, one counter per side.
    int                calm_tx;
    int                calm_rx;

    sustained_threshold_alarm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Random idle cycles before the next item, but now and then a run of
    // items with no idling at all so that back-to-back traffic is covered.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [VALUE_W-1:0] rand40();
        return VALUE_W'({$urandom, $urandom});
    endfunction

    // A value on the chosen side of the threshold. A strict pick lands on the
    // threshold only if that side is empty; a loose pick may hit it. Half the
    // picks sit within a few units of the bound to hit the compare edge.
    function automatic logic [VALUE_W-1:0] value_around(logic [VALUE_W-1:0] thr,
                                                         logic [VALUE_W-1:0] top,
                                                         bit high, bit strict);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] off;
        if (high) begin
            lo = 64'(thr) + 64'(strict);
            hi = 64'(top);
        end else begin
            if (strict && thr == 0)
                return '0;
            lo = '0;
            hi = 64'(thr) - 64'(strict);
            if (hi > 64'(top))
                hi = 64'(top);
        end
        if (lo > hi)
            return top;
        if ($urandom_range(0, 1) == 1)
            off = 64'($urandom_range(0, 3));
        else
            off = {$urandom, $urandom};
        if (off > hi - lo)
            off = off % (hi - lo + 1);
        return high ? VALUE_W'(lo + off) : VALUE_W'(hi - off);
    endfunction

    // Mostly forward steps of up to 1.5 s, with the odd step backwards and
    // the odd jump of days; big_steps makes the jumps common so that the
    // largest sustain and cooldown settings can be reached.
    function automatic void advance_time(bit big_steps);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            cur_time = cur_time - $urandom_range(1, 3000);
        else if (r == 1 || (big_steps && r < 8))
            cur_time = cur_time + $urandom_range(1 << 26, 1 << 28);
        else
            cur_time = cur_time + $urandom_range(0, 1500);
    endfunction

    function automatic sample_fields_t mk(logic [TIME_W-1:0] t, logic [PCT_W-1:0] cpu,
                                          logic [PCT_W-1:0] mem, logic [RATE_W-1:0] dl,
                                          logic [RATE_W-1:0] ul, logic link);
        sample_fields_t smp;
        smp.time_ms       = t;
        smp.cpu_pct       = cpu;
        smp.memory_pct    = mem;
        smp.download_rate = dl;
        smp.upload_rate   = ul;
        smp.link_up       = link;
        return smp;
    endfunction

    // Random sample whose selected metric falls into or out of breach as
    // asked. A few samples are all zeros, all full scale or pure noise.
    function automatic sample_fields_t random_sample(logic [METRIC_W-1:0] metric,
                                                     logic below,
                                                     logic [VALUE_W-1:0] thr,
                                                     bit in_breach);
        sample_fields_t     smp;
        logic [VALUE_W-1:0] v;
        int                 mode;
        smp = mk(cur_time, PCT_W'($urandom_range(0, 10000)),
                 PCT_W'($urandom_range(0, 10000)),
                 rand40(), rand40(), 1'($urandom_range(0, 1)));
        mode = $urandom_range(0, 15);
        if (mode == 0) begin
            smp = mk(cur_time, 0, 0, 0, 0, 0);
        end else if (mode == 1) begin
            smp = mk(cur_time, 10000, 10000, MAX40, MAX40, 1'b1);
        end else if (mode > 2) begin
            case (metric)
                METRIC_CPU: begin
                    v = value_around(thr, PCT_TOP, in_breach != below, in_breach);
                    smp.cpu_pct = v[PCT_W-1:0];
                end
                METRIC_MEMORY: begin
                    v = value_around(thr, PCT_TOP, in_breach != below, in_breach);
                    smp.memory_pct = v[PCT_W-1:0];
                end
                METRIC_DOWNLOAD:
                    smp.download_rate = value_around(thr, MAX40, in_breach != below, in_breach);
                METRIC_UPLOAD:
                    smp.upload_rate = value_around(thr, MAX40, in_breach != below, in_breach);
                METRIC_LINK: begin
                    v = value_around(thr, 40'd1, in_breach != below, in_breach);
                    smp.link_up = v[0];
                end
                default: ;
            endcase
        end
        return smp;
    endfunction

    // Offers one item and returns at the edge where it is taken. The valid
    // stays high straight into the next item when no idle cycles are drawn.
    task automatic send_sample(input sample_fields_t smp);
        int gap;
        gap = draw_wait(calm_tx);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, smp};
        do @(posedge aclk); while (!s_tready);
        tracker.note_sample(smp);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        tracker.set_reg(idx, val);
    endtask

    task automatic configure_rule(logic en, logic [METRIC_W-1:0] metric, logic below,
                                  logic [VALUE_W-1:0] thr, logic [MS_W-1:0] sustain,
                                  logic [MS_W-1:0] cool);
        write_reg(REG_RULE_ENABLED, CFG_DATA_W'(en));
        write_reg(REG_METRIC_SELECT, CFG_DATA_W'(metric));
        write_reg(REG_TRIGGER_BELOW, CFG_DATA_W'(below));
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SUSTAIN_MS, CFG_DATA_W'(sustain));
        write_reg(REG_COOLDOWN_MS, CFG_DATA_W'(cool));
        cfg_wr_en <= 1'b0;
    endtask

    // Stops offering items, waits for every owed event, then lets the last
    // sample clear the two-stage pipeline even if it raised no event. Events
    // that never show up are failures and are dropped so later checks line up.
    task automatic wait_idle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (tracker.pending_events.size() != 0) begin
            $error("%0d expected events never arrived", tracker.pending_events.size());
            tracker.errors++;
            tracker.pending_events.delete();
        end
        repeat (6) @(posedge aclk);
    endtask

    // One configuration followed by a stream of samples whose selected metric
    // moves in and out of breach in runs of a few items.
    task automatic run_phase(logic en, logic [METRIC_W-1:0] metric, logic below,
                             logic [VALUE_W-1:0] thr, logic [MS_W-1:0] sustain,
                             logic [MS_W-1:0] cool, int count, bit big_steps);
        bit in_breach;
        wait_idle();
        configure_rule(en, metric, below, thr, sustain, cool);
        in_breach = 1'($urandom_range(0, 1));
        repeat (count) begin
            if ($urandom_range(0, 4) == 0)
                in_breach = !in_breach;
            advance_time(big_steps);
            send_sample(random_sample(metric, below, thr, in_breach));
        end
    endtask

    // Event receiver: random stalls per item, plus one long hold-off when
    // the stimulus asks for it. Every accepted event is checked at once.
    initial begin
        int stall;
        m_tready <= 1'b0;
        calm_rx = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(calm_rx);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_event(m_tuser, m_tdata);
        end
    end

    initial begin
        logic [METRIC_W-1:0] mix_metric;
        logic                mix_below;
        logic [VALUE_W-1:0]  mix_thr;
        bit                  toggle;

        tracker = new;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        long_hold_req = 1'b0;
        calm_tx  = 0;
        cur_time = $urandom;
        toggle   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The rule comes out of reset disabled: these two field extremes must
        // be swallowed without an event.
        send_sample(mk(32'd0, 0, 0, 0, 0, 1'b0));
        send_sample(mk(32'hFFFF_FFFF, 10000, 10000, MAX40, MAX40, 1'b1));

        // CPU above 50.00 %, 2 s sustain, 5 s cooldown. The breach starts at
        // 1000 ms; 1999 ms of breach still counts as one whole second, and the
        // trigger comes at exactly two seconds.
        wait_idle();
        configure_rule(1'b1, METRIC_CPU, 1'b0, 40'd5000, 27'd2000, 27'd5000);
        send_sample(mk(32'd1000, 6000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd2500, 6000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd2999, 6000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd3000, 6000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd3500, 10000, 0, 0, 0, 1'b0));
        // A value equal to the threshold is not a breach, so the alarm recovers.
        send_sample(mk(32'd4000, 5000, 0, 0, 0, 1'b0));
        // New breach: sustain is met at 7000 ms but the cooldown holds it off
        // until 8000 ms.
        send_sample(mk(32'd4100, 9000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd7000, 9000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd8000, 9000, 0, 0, 0, 1'b0));
        send_sample(mk(32'd8100, 0, 0, 0, 0, 1'b0));

        // Download below the largest threshold: only full scale escapes breach.
        wait_idle();
        configure_rule(1'b1, METRIC_DOWNLOAD, 1'b1, MAX40, 27'd0, 27'd0);
        send_sample(mk(32'd9000, 0, 0, MAX40, 0, 1'b0));
        send_sample(mk(32'd9100, 0, 0, 0, 0, 1'b0));
        send_sample(mk(32'd9200, 0, 0, MAX40, 0, 1'b0));

        // An unknown metric code reads as zero whatever the sample holds, and
        // the event still carries the code as written.
        wait_idle();
        configure_rule(1'b1, 3'd7, 1'b1, 40'd1, 27'd0, 27'd0);
        send_sample(mk(32'd9300, 10000, 10000, MAX40, MAX40, 1'b1));
        send_sample(mk(32'd9400, 10000, 10000, MAX40, MAX40, 1'b1));

        // Link state above zero. The alarm is still active from the last
        // setting, so the first breach raises nothing.
        wait_idle();
        configure_rule(1'b1, METRIC_LINK, 1'b0, 40'd0, 27'd0, 27'd0);
        send_sample(mk(32'd9500, 0, 0, 0, 0, 1'b1));
        send_sample(mk(32'd9600, 0, 0, 0, 0, 1'b0));
        send_sample(mk(32'd9700, 0, 0, 0, 0, 1'b1));

        // Upload with the longest cooldown, across the timestamp wrap: the
        // breach from just below 2^32 reaches one second after the wrap.
        wait_idle();
        configure_rule(1'b1, METRIC_UPLOAD, 1'b0, 40'd100, 27'd1000, MAX27);
        send_sample(mk(32'hFFFF_FE00, 0, 0, 0, 0, 1'b0));
        send_sample(mk(32'hFFFF_FF00, 0, 0, 0, MAX40, 1'b0));
        send_sample(mk(32'h0000_0300, 0, 0, 0, MAX40, 1'b0));

        // Memory below full scale; time then steps backwards, which makes both
        // the breach age and the cooldown age wrap to huge values.
        wait_idle();
        configure_rule(1'b1, METRIC_MEMORY, 1'b1, 40'd10000, 27'd1000, MAX27);
        send_sample(mk(32'h0000_0400, 0, 9999, 0, 0, 1'b0));
        send_sample(mk(32'h0000_0450, 0, 10000, 0, 0, 1'b0));
        send_sample(mk(32'h0000_0500, 0, 0, 0, 0, 1'b0));
        send_sample(mk(32'h0000_0200, 0, 0, 0, 0, 1'b0));

        // Random part, one fixed setting per phase.
        run_phase(1'b1, METRIC_CPU, 1'b0, 40'($urandom_range(0, 10000)),
                  27'd1000, 27'd3000, 170, 1'b0);
        run_phase(1'b1, METRIC_MEMORY, 1'b1, 40'($urandom_range(0, 10000)),
                  27'd0, 27'd0, 170, 1'b0);
        run_phase(1'b1, METRIC_DOWNLOAD, 1'b0, rand40(), 27'd2500, 27'd0, 170, 1'b0);
        run_phase(1'b1, METRIC_UPLOAD, 1'b1, rand40(), 27'd0, 27'd10000, 170, 1'b0);
        run_phase(1'b1, METRIC_LINK, 1'b0, 40'd0, 27'd1500, 27'd1000, 170, 1'b0);
        // Rule switched off: samples must pass without effect on the state.
        run_phase(1'b0, METRIC_CPU, 1'b0, 40'd5000, 27'd0, 27'd0, 40, 1'b0);
        // Extremes of the timing registers, reached through large time jumps.
        run_phase(1'b1, METRIC_CPU, 1'b0, 40'd0, MAX27, MAX27, 170, 1'b1);
        run_phase(1'b1, METRIC_DOWNLOAD, 1'b1, MAX40, 27'd0, MAX27, 170, 1'b1);
        run_phase(1'b1, 3'($urandom_range(5, 7)), 1'b1, 40'($urandom_range(1, 1000)),
                  27'd0, 27'd0, 60, 1'b0);
        run_phase(1'b1, METRIC_LINK, 1'b1, 40'd1, 27'd500, 27'd0, 170, 1'b0);
        // Restart the clock just short of the wrap.
        cur_time = 32'hFFFF_0000;
        run_phase(1'b1, METRIC_CPU, 1'b0, 40'($urandom_range(0, 10000)),
                  27'd999, 27'd1, 170, 1'b0);

        // Back-pressure: each sample asks for the opposite breach state, so most
        // raise an event, while the receiver holds off for a long stretch. The block
        // fills up and has to stall its input.
        wait_idle();
        configure_rule(1'b1, METRIC_CPU, 1'b0, 40'd5000, 27'd0, 27'd0);
        long_hold_req = 1'b1;
        repeat (40) begin
            toggle = !toggle;
            advance_time(1'b0);
            send_sample(random_sample(METRIC_CPU, 1'b0, 40'd5000, toggle));
        end

        // Random settings for the rest of the run.
        repeat (3) begin
            mix_metric = METRIC_W'($urandom_range(0, 4));
            mix_below  = 1'($urandom_range(0, 1));
            case (mix_metric)
                METRIC_CPU, METRIC_MEMORY: mix_thr = VALUE_W'($urandom_range(0, 10000));
                METRIC_LINK:               mix_thr = VALUE_W'(mix_below);
                default:                   mix_thr = rand40();
            endcase
            run_phase(1'b1, mix_metric, mix_below, mix_thr, 27'($urandom_range(0, 4000)),
                      27'($urandom_range(0, 6000)), 170, 1'b0);
        end

        wait_idle();
        if (tracker.errors == 0)
            $display("** sustained_threshold_alarm_top: PASSED **");
        else
            $display("** sustained_threshold_alarm_top: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("** sustained_threshold_alarm_top: FAILED **");
        $finish;
    end

endmodule

// ===== sustained_threshold_alarm_top.f =====
design/stalarm_pkg.sv
design/stalarm_cfg.sv
design/stalarm_in_stage.sv
design/stalarm_eval.sv
design/sustained_threshold_alarm_top.sv
design/stalarm_checker.sv
verif/tb.sv
